[rtl/xlt_pkg.sv]
`default_nettype none
package xlt_pkg;

  localparam int unsigned MaxDepthDefault = 256;
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned MaxRes = 3;

  localparam logic [7:0] ChLt    = 8'h3C;
  localparam logic [7:0] ChSlash = 8'h2F;
  localparam logic [7:0] ChGt    = 8'h3E;
  localparam logic [7:0] ChBang  = 8'h21;
  localparam logic [7:0] ChDash  = 8'h2D;
  localparam logic [7:0] ChColon = 8'h3A;
  localparam logic [7:0] ChEq    = 8'h3D;
  localparam logic [7:0] ChQuote = 8'h22;
  localparam logic [7:0] ChLf    = 8'h0A;

  typedef enum logic [4:0] {
    PH_START, PH_TAGSP, PH_LT, PH_ONAME, PH_ONAME2, PH_OSP, PH_SCSP,
    PH_ANAME, PH_ANAME2, PH_AEQ, PH_AQ, PH_AVAL, PH_VSTART, PH_VAL,
    PH_CLSP, PH_CLNAME, PH_CLNAME2, PH_CLEND, PH_CMD1, PH_CMD2,
    PH_CMBODY, PH_CMDASH, PH_CMDASH2
  } phase_t;

  typedef enum logic [3:0] {
    EV_TAGCHAR, EV_PREFIX, EV_TAGOPEN, EV_ATTRCHAR, EV_ATTRPREFIX,
    EV_ATTRVALCHAR, EV_ATTRDONE, EV_VALCHAR, EV_VALDONE, EV_TAGCLOSED,
    EV_DOCOK, EV_ERROR
  } event_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] byte_in;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  event_res;
    logic [7:0]  char_code;
    logic        nonblank;
    logic [15:0] error_line;
    logic [15:0] error_column;
    logic        last;
  } out_item_t;

  typedef struct packed {
    event_t     ev;
    logic [7:0] ch;
    logic       nb;
  } slot_t;

  typedef struct packed {
    logic [1:0]  cnt;
    slot_t [2:0] slot;
    logic [15:0] line;
    logic [15:0] col;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  function automatic entry_t push_ev(entry_t e, event_t ev, logic [7:0] ch, logic nb);
    entry_t r;
    r = e;
    if (r.cnt < 2'(MaxRes)) begin
      r.slot[r.cnt].ev = ev;
      r.slot[r.cnt].ch = ch;
      r.slot[r.cnt].nb = nb;
      r.cnt = r.cnt + 2'd1;
    end
    return r;
  endfunction

  function automatic logic is_blank(logic [7:0] c);
    return (c == 8'd32) || ((c >= 8'd9) && (c <= 8'd13));
  endfunction

  function automatic logic is_alnum(logic [7:0] c);
    return ((c >= 8'h30) && (c <= 8'h39)) || ((c >= 8'h41) && (c <= 8'h5A)) ||
           ((c >= 8'h61) && (c <= 8'h7A));
  endfunction

endpackage
`default_nettype wire

[rtl/xml_lite_tokenizer.sv]
// Each result is registered in the queue before the serializer presents it.
// Throughput: one input byte per cycle while the queue is not full; the result side moves
// one event per cycle unless result_stall is high, an item with k events taking k transfers.
// A four-entry queue between the parser and the event serializer absorbs bursts.
// Reset (rst, synchronous): parser to document start, line and column to 1, queue empty.
`default_nettype none
module xml_lite_tokenizer import xlt_pkg::*; #(
  parameter int unsigned MAX_DEPTH = MaxDepthDefault
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     item_valid,
  output logic          item_stall,
  input  wire in_item_t item,
  output logic          result_valid,
  input  wire logic     result_stall,
  output out_item_t     result
);

  logic          push, pop;
  entry_t        push_entry, head;
  queue_status_t status;

  xlt_front #(.MAX_DEPTH(MAX_DEPTH)) u_front (
    .clk, .rst, .item_valid, .item_stall, .item,
    .queue_full(status.full), .push, .push_entry
  );

  xlt_fifo u_fifo (.clk, .rst, .push, .push_entry, .pop, .head, .status);

  xlt_back u_back (
    .clk, .rst, .head, .status, .pop, .result_valid, .result_stall, .result
  );

`ifndef SYNTHESIS
  a_stall_needs_backlog: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> result_valid)
    else $error("input stalled with no pending result");
  a_loc_only_on_error: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.event_res != EV_ERROR) |->
      (result.error_line == 16'd0 && result.error_column == 16'd0))
    else $error("location on a non-error event");
  a_status_is_last: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.event_res == EV_DOCOK) |-> result.last)
    else $error("docok not last");
`endif

endmodule
`default_nettype wire

[rtl/xlt_front.sv]
`default_nettype none
module xlt_front import xlt_pkg::*; #(
  parameter int unsigned MAX_DEPTH = MaxDepthDefault
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     item_valid,
  output logic          item_stall,
  input  wire in_item_t item,
  input  wire logic     queue_full,
  output logic          push,
  output entry_t        push_entry
);

  localparam int unsigned DW = $clog2(MAX_DEPTH + 1);

  phase_t        phase, phase_next;
  logic [DW-1:0] depth, depth_next;
  logic          vnb, vnb_next;
  logic [15:0]   line, line_next;
  logic [15:0]   col, col_next;
  logic          errl, errl_next;
  logic          accept;

  assign item_stall = queue_full;
  assign accept = item_valid && !queue_full;
  assign push = accept && (push_entry.cnt != 2'd0);

  always_comb begin
    phase_t        ph;
    logic          again;
    logic [7:0]    c;
    entry_t        e;
    ph = phase;
    c = item.byte_in;
    e = '0;
    e.line = line;
    e.col = col;
    again = 1'b1;
    depth_next = depth;
    vnb_next = vnb;
    errl_next = errl;
    line_next = line;
    col_next = col;
    if (item.kind) begin
      if (errl) begin
        e = push_ev(e, EV_ERROR, 8'd0, 1'b0);
      end else begin
        unique case (phase)
          PH_TAGSP, PH_VSTART: begin
            e = push_ev(e, (depth != '0) ? EV_ERROR : EV_DOCOK, 8'd0, 1'b0);
          end
          PH_VAL: begin
            e = push_ev(e, EV_VALDONE, 8'd0, vnb);
            e = push_ev(e, (depth != '0) ? EV_ERROR : EV_DOCOK, 8'd0, 1'b0);
          end
          PH_ONAME, PH_ONAME2: begin
            e = push_ev(e, EV_TAGOPEN, 8'd0, 1'b0);
            e = push_ev(e, EV_ERROR, 8'd0, 1'b0);
          end
          default: e = push_ev(e, EV_ERROR, 8'd0, 1'b0);
        endcase
      end
      ph = PH_START;
      depth_next = '0;
      vnb_next = 1'b0;
      line_next = 16'd1;
      col_next = 16'd1;
      errl_next = 1'b0;
    end else if (!errl) begin
      for (int i = 0; i < 5; i++) begin
        if (again && !errl_next) begin
          again = 1'b0;
          unique case (ph)
            PH_START, PH_TAGSP: begin
              if (c == ChLt) ph = PH_LT;
              else if (!is_blank(c)) begin
                e = push_ev(e, EV_ERROR, 8'd0, 1'b0);
                errl_next = 1'b1;
              end
            end
            PH_LT: begin
              if (c == ChSlash) ph = PH_CLSP;
              else if (c == ChBang) ph = PH_CMD1;
              else if (!is_blank(c)) begin
                ph = PH_ONAME;
                again = 1'b1;
              end
            end
            PH_ONAME, PH_ONAME2: begin
              if (is_alnum(c)) e = push_ev(e, EV_TAGCHAR, c, 1'b0);
              else if (c == ChColon && ph == PH_ONAME) begin
                e = push_ev(e, EV_PREFIX, 8'd0, 1'b0);
                ph = PH_ONAME2;
              end else begin
                e = push_ev(e, EV_TAGOPEN, 8'd0, 1'b0);
                if (depth_next >= DW'(MAX_DEPTH)) begin
                  e = push_ev(e, EV_ERROR, 8'd0, 1'b0);
                  errl_next = 1'b1;
                end else begin
                  depth_next = depth_next + DW'(1);
                  ph = PH_OSP;
                  again = 1'b1;
                end
              end
            end
            PH_OSP: begin
              if (c == ChSlash) ph = PH_SCSP;
              else if (c == ChGt) ph = PH_VSTART;
              else if (!is_blank(c)) begin
                ph = PH_ANAME;
                again = 1'b1;
              end
            end
            PH_SCSP, PH_CLEND: begin
              if (c == ChGt) begin
                e = push_ev(e, EV_TAGCLOSED, 8'd0, 1'b0);
                if (depth_next == '0) begin
                  e = push_ev(e, EV_ERROR, 8'd0, 1'b0);
                  errl_next = 1'b1;
                end else begin
                  depth_next = depth_next - DW'(1);
                  ph = (ph == PH_SCSP) ? PH_TAGSP : PH_VSTART;
                end
              end else if (!is_blank(c)) begin
                e = push_ev(e, EV_ERROR, 8'd0, 1'b0);
                errl_next = 1'b1;
              end
            end
            PH_ANAME, PH_ANAME2: begin
              if (is_alnum(c)) e = push_ev(e, EV_ATTRCHAR, c, 1'b0);
              else if (c == ChColon && ph == PH_ANAME) begin
                e = push_ev(e, EV_ATTRPREFIX, 8'd0, 1'b0);
                ph = PH_ANAME2;
              end else begin
                ph = PH_AEQ;
                again = 1'b1;
              end
            end
            PH_AEQ, PH_AQ: begin
              if (ph == PH_AEQ && c == ChEq) ph = PH_AQ;
              else if (ph == PH_AQ && c == ChQuote) ph = PH_AVAL;
              else if (!is_blank(c)) begin
                e = push_ev(e, EV_ERROR, 8'd0, 1'b0);
                errl_next = 1'b1;
              end
            end
            PH_AVAL: begin
              if (c == ChQuote) begin
                e = push_ev(e, EV_ATTRDONE, 8'd0, 1'b0);
                ph = PH_OSP;
              end else e = push_ev(e, EV_ATTRVALCHAR, c, 1'b0);
            end
            PH_VSTART, PH_VAL: begin
              if (c == ChLt) begin
                if (ph == PH_VAL) e = push_ev(e, EV_VALDONE, 8'd0, vnb_next);
                vnb_next = 1'b0;
                ph = PH_LT;
              end else begin
                if (ph == PH_VSTART) vnb_next = 1'b0;
                if (!is_blank(c)) vnb_next = 1'b1;
                e = push_ev(e, EV_VALCHAR, c, 1'b0);
                ph = PH_VAL;
              end
            end
            PH_CLSP: begin
              if (!is_blank(c)) begin
                ph = PH_CLNAME;
                again = 1'b1;
              end
            end
            PH_CLNAME, PH_CLNAME2: begin
              if (is_alnum(c)) ph = ph;
              else if (c == ChColon && ph == PH_CLNAME) ph = PH_CLNAME2;
              else begin
                ph = PH_CLEND;
                again = 1'b1;
              end
            end
            PH_CMD1, PH_CMD2: begin
              if (c == ChDash) ph = (ph == PH_CMD1) ? PH_CMD2 : PH_CMBODY;
              else begin
                e = push_ev(e, EV_ERROR, 8'd0, 1'b0);
                errl_next = 1'b1;
              end
            end
            PH_CMBODY: if (c == ChDash) ph = PH_CMDASH;
            PH_CMDASH: ph = (c == ChDash) ? PH_CMDASH2 : PH_CMBODY;
            PH_CMDASH2: ph = (c == ChGt) ? PH_TAGSP : PH_CMBODY;
            default: begin
              e = push_ev(e, EV_ERROR, 8'd0, 1'b0);
              errl_next = 1'b1;
            end
          endcase
        end
      end
      if (!errl_next) begin
        if (c == ChLf) begin
          if (line != 16'hFFFF) line_next = line + 16'd1;
          col_next = 16'd1;
        end else if (col != 16'hFFFF) begin
          col_next = col + 16'd1;
        end
      end
    end
    phase_next = ph;
    push_entry = e;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_START;
      depth <= '0;
      vnb <= 1'b0;
      line <= 16'd1;
      col <= 16'd1;
      errl <= 1'b0;
    end else if (accept) begin
      phase <= phase_next;
      depth <= depth_next;
      vnb <= vnb_next;
      line <= line_next;
      col <= col_next;
      errl <= errl_next;
    end
  end

endmodule
`default_nettype wire

[rtl/xlt_fifo.sv]
`default_nettype none
module xlt_fifo import xlt_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   push,
  input  wire entry_t push_entry,
  input  wire logic   pop,
  output entry_t      head,
  output queue_status_t status
);

  localparam int unsigned AW = $clog2(QueueDepth);
  localparam int unsigned CW = $clog2(QueueDepth + 1);

  entry_t        store [QueueDepth];
  logic [AW-1:0] wptr, rptr;
  logic [CW-1:0] count;

  assign status.full = (count == CW'(QueueDepth));
  assign status.empty = (count == '0);
  assign head = store[rptr];

  always_ff @(posedge clk) begin
    if (push) store[wptr] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= AW'((32'(wptr) + 1) % QueueDepth);
      if (pop) rptr <= AW'((32'(rptr) + 1) % QueueDepth);
      count <= count + CW'(push) - CW'(pop);
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) status.full |-> !push)
    else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) status.empty |-> !pop)
    else $error("pop from empty queue");
  a_count_range: assert property (@(posedge clk) disable iff (rst) count <= CW'(QueueDepth))
    else $error("queue count out of range");
`endif

endmodule
`default_nettype wire

[rtl/xlt_back.sv]
`default_nettype none
module xlt_back import xlt_pkg::*; (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire entry_t        head,
  input  wire queue_status_t status,
  output logic               pop,
  output logic               result_valid,
  input  wire logic          result_stall,
  output out_item_t          result
);

  logic [1:0] idx;
  slot_t      s;
  logic       is_last;

  assign s = head.slot[idx];
  assign is_last = (idx == head.cnt - 2'd1);
  assign result_valid = !status.empty;
  assign pop = result_valid && !result_stall && is_last;

  always_comb begin
    result.event_res = s.ev;
    result.char_code = s.ch;
    result.nonblank = s.nb;
    result.error_line = (s.ev == EV_ERROR) ? head.line : 16'd0;
    result.error_column = (s.ev == EV_ERROR) ? head.col : 16'd0;
    result.last = is_last;
  end

  always_ff @(posedge clk) begin
    if (rst) idx <= 2'd0;
    else if (result_valid && !result_stall) idx <= is_last ? 2'd0 : idx + 2'd1;
  end

endmodule
`default_nettype wire

[tb/tb.sv]
`timescale 1ns / 1ps
module tb;
  import xlt_pkg::*;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      item_valid = 1'b0;
  logic      item_stall;
  in_item_t  item = '0;
  logic      result_valid;
  logic      result_stall = 1'b0;
  out_item_t result;

  xml_lite_tokenizer u_dut (
    .clk(clk), .rst(rst), .item_valid(item_valid), .item_stall(item_stall), .item(item),
    .result_valid(result_valid), .result_stall(result_stall), .result(result)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  in_item_t  pending_q[$];
  out_item_t events_q[$];
  int        errors = 0;
  int        n_sent = 0;
  bit        stim_done = 1'b0;
  bit        hold_long = 1'b0;

  phase_t      ph;
  logic [8:0]  depth;
  logic        seen_nb;
  logic [15:0] line_no;
  logic [15:0] col_no;
  logic        err_l;

  function automatic bit blank_ch(logic [7:0] c);
    return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic bit alnum_ch(logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction

  task automatic parser_clear();
    ph = PH_START; depth = '0; seen_nb = 1'b0;
    line_no = 16'd1; col_no = 16'd1; err_l = 1'b0;
  endtask

  task automatic add_event(ref out_item_t evs[$], input event_t ev, input logic [7:0] ch,
                           input logic nb);
    out_item_t r;
    if (evs.size() >= MaxRes) return;
    r = '0;
    r.event_res = ev; r.char_code = ch; r.nonblank = nb;
    if (ev == EV_ERROR) begin
      r.error_line = line_no; r.error_column = col_no;
    end
    evs.push_back(r);
  endtask

  task automatic raise_error(ref out_item_t evs[$]);
    add_event(evs, EV_ERROR, 8'd0, 1'b0);
    err_l = 1'b1;
  endtask

  task automatic tokenize(input in_item_t it);
    out_item_t evs[$];
    logic [7:0] c;
    bit again;
    c = it.byte_in;
    if (it.kind) begin
      if (err_l) add_event(evs, EV_ERROR, 8'd0, 1'b0);
      else case (ph)
        PH_TAGSP, PH_VSTART, PH_VAL: begin
          if (ph == PH_VAL) add_event(evs, EV_VALDONE, 8'd0, seen_nb);
          add_event(evs, depth != 0 ? EV_ERROR : EV_DOCOK, 8'd0, 1'b0);
        end
        PH_ONAME, PH_ONAME2: begin
          add_event(evs, EV_TAGOPEN, 8'd0, 1'b0);
          add_event(evs, EV_ERROR, 8'd0, 1'b0);
        end
        default: add_event(evs, EV_ERROR, 8'd0, 1'b0);
      endcase
      parser_clear();
    end else if (!err_l) begin
      again = 1'b1;
      while (again && !err_l) begin
        again = 1'b0;
        case (ph)
          PH_START, PH_TAGSP: begin
            if (c == ChLt) ph = PH_LT;
            else if (!blank_ch(c)) raise_error(evs);
          end
          PH_LT: begin
            if (c == ChSlash) ph = PH_CLSP;
            else if (c == ChBang) ph = PH_CMD1;
            else if (!blank_ch(c)) begin
              ph = PH_ONAME; again = 1'b1;
            end
          end
          PH_ONAME, PH_ONAME2: begin
            if (alnum_ch(c)) add_event(evs, EV_TAGCHAR, c, 1'b0);
            else if (c == ChColon && ph == PH_ONAME) begin
              add_event(evs, EV_PREFIX, 8'd0, 1'b0); ph = PH_ONAME2;
            end else begin
              add_event(evs, EV_TAGOPEN, 8'd0, 1'b0);
              if (depth >= MaxDepthDefault) raise_error(evs);
              else begin
                depth++; ph = PH_OSP; again = 1'b1;
              end
            end
          end
          PH_OSP: begin
            if (c == ChSlash) ph = PH_SCSP;
            else if (c == ChGt) ph = PH_VSTART;
            else if (!blank_ch(c)) begin
              ph = PH_ANAME; again = 1'b1;
            end
          end
          PH_SCSP, PH_CLEND: begin
            if (c == ChGt) begin
              add_event(evs, EV_TAGCLOSED, 8'd0, 1'b0);
              if (depth == 0) raise_error(evs);
              else begin
                depth--; ph = (ph == PH_SCSP) ? PH_TAGSP : PH_VSTART;
              end
            end else if (!blank_ch(c)) raise_error(evs);
          end
          PH_ANAME, PH_ANAME2: begin
            if (alnum_ch(c)) add_event(evs, EV_ATTRCHAR, c, 1'b0);
            else if (c == ChColon && ph == PH_ANAME) begin
              add_event(evs, EV_ATTRPREFIX, 8'd0, 1'b0); ph = PH_ANAME2;
            end else begin
              ph = PH_AEQ; again = 1'b1;
            end
          end
          PH_AEQ: begin
            if (c == ChEq) ph = PH_AQ;
            else if (!blank_ch(c)) raise_error(evs);
          end
          PH_AQ: begin
            if (c == ChQuote) ph = PH_AVAL;
            else if (!blank_ch(c)) raise_error(evs);
          end
          PH_AVAL: begin
            if (c == ChQuote) begin
              add_event(evs, EV_ATTRDONE, 8'd0, 1'b0); ph = PH_OSP;
            end else add_event(evs, EV_ATTRVALCHAR, c, 1'b0);
          end
          PH_VSTART, PH_VAL: begin
            if (c == ChLt) begin
              if (ph == PH_VAL) add_event(evs, EV_VALDONE, 8'd0, seen_nb);
              seen_nb = 1'b0; ph = PH_LT;
            end else begin
              if (ph == PH_VSTART) seen_nb = 1'b0;
              if (!blank_ch(c)) seen_nb = 1'b1;
              add_event(evs, EV_VALCHAR, c, 1'b0);
              ph = PH_VAL;
            end
          end
          PH_CLSP: begin
            if (!blank_ch(c)) begin
              ph = PH_CLNAME; again = 1'b1;
            end
          end
          PH_CLNAME, PH_CLNAME2: begin
            if (alnum_ch(c)) ;
            else if (c == ChColon && ph == PH_CLNAME) ph = PH_CLNAME2;
            else begin
              ph = PH_CLEND; again = 1'b1;
            end
          end
          PH_CMD1: begin
            if (c == ChDash) ph = PH_CMD2;
            else raise_error(evs);
          end
          PH_CMD2: begin
            if (c == ChDash) ph = PH_CMBODY;
            else raise_error(evs);
          end
          PH_CMBODY: if (c == ChDash) ph = PH_CMDASH;
          PH_CMDASH: ph = (c == ChDash) ? PH_CMDASH2 : PH_CMBODY;
          PH_CMDASH2: ph = (c == ChGt) ? PH_TAGSP : PH_CMBODY;
          default: raise_error(evs);
        endcase
      end
      if (!err_l) begin
        if (c == ChLf) begin
          if (line_no != 16'hFFFF) line_no++;
          col_no = 16'd1;
        end else if (col_no != 16'hFFFF) col_no++;
      end
    end
    if (evs.size() > 0) evs[evs.size()-1].last = 1'b1;
    foreach (evs[i]) events_q.push_back(evs[i]);
  endtask

  task automatic add_text(string s);
    in_item_t it;
    for (int i = 0; i < s.len(); i++) begin
      it.kind = 1'b0; it.byte_in = s[i];
      pending_q.push_back(it);
    end
  endtask

  task automatic add_end();
    in_item_t it;
    it.kind = 1'b1; it.byte_in = 8'($urandom);
    pending_q.push_back(it);
  endtask

  function automatic string rand_name(int maxlen);
    string s;
    string alpha;
    int n;
    int k;
    alpha = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789";
    s = "";
    n = $urandom_range(0, maxlen);
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 61);
      s = {s, alpha.substr(k, k)};
    end
    if ($urandom_range(0, 4) == 0) s = {s, ":", rand_name(3)};
    return s;
  endfunction

  function automatic string rand_text(int maxlen);
    string s;
    byte b;
    s = "";
    for (int i = $urandom_range(0, maxlen); i > 0; i--) begin
      case ($urandom_range(0, 5))
        0: b = " ";
        1: b = 8'h0A;
        2: b = 8'($urandom_range(128, 255));
        default: b = 8'($urandom_range(35, 59));
      endcase
      s = {s, string'(b)};
    end
    return s;
  endfunction

  function automatic string rand_element(int lvl);
    string s;
    string nm;
    nm = rand_name(4);
    s = {"<", nm};
    repeat ($urandom_range(0, 2))
      s = {s, " ", rand_name(3), " = \"", rand_text(3), "\""};
    if (lvl > 2 || $urandom_range(0, 2) == 0) return {s, " />"};
    s = {s, ">", rand_text(4)};
    repeat ($urandom_range(0, 2)) begin
      if ($urandom_range(0, 4) == 0) s = {s, "<!-- x -->"};
      else s = {s, rand_element(lvl + 1), rand_text(3)};
    end
    return {s, "</ ", nm, " >"};
  endfunction

  task automatic add_noise(int n);
    in_item_t it;
    repeat (n) begin
      it.kind = ($urandom_range(0, 15) == 0);
      it.byte_in = 8'($urandom);
      pending_q.push_back(it);
    end
  endtask

  task automatic wait_drained();
    while (pending_q.size() != 0 || events_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  initial begin
    string doc;
    int pick;
    int room;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    add_text("<a:b x=\"1\" p:q=\"\xff\"> hi\t</a >"); add_end();
    add_text("<!--a--->b-->"); add_end();
    add_text("  \n "); add_end();
    add_text("</x>"); add_end();
    add_text("<a"); add_end();
    add_text("<a><b/>"); add_end();
    add_text("<a>\n?"); add_end();
    add_text("<!x"); add_end();
    add_text("<a x y>"); add_end();
    add_text("<:>  \x00"); add_end();
    wait_drained();
    while (n_sent + pending_q.size() < 370) begin
      room = 380 - n_sent - pending_q.size();
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
        doc = rand_element(0);
        if ($urandom_range(0, 3) == 0) doc = {" \n", doc, "<!-- c -->"};
        if (doc.len() > room - 1) doc = doc.substr(0, room - 2);
        add_text(doc);
      end else if (pick < 9) begin
        doc = rand_element(0);
        doc = doc.substr(0, $urandom_range(0, doc.len() - 1));
        if (doc.len() > room - 1) doc = doc.substr(0, room - 2);
        add_text(doc);
      end else add_noise($urandom_range(1, 9));
      add_end();
      while (pending_q.size() > 40) @(posedge clk);
    end
    wait_drained();
    stim_done = 1'b1;
  end

  int burst_left = 0;
  int gap_left = 0;
  always @(negedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!(item_valid && item_stall)) begin
      if (item_valid) void'(pending_q.pop_front());
      if (gap_left > 0) begin
        gap_left--;
        item_valid <= 1'b0;
      end else if (pending_q.size() > 0) begin
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 30);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 4);
        end
        burst_left--;
        item_valid <= 1'b1;
        item <= pending_q[0];
        tokenize(pending_q[0]);
        n_sent++;
      end else begin
        item_valid <= 1'b0;
      end
    end
  end

  int stall_mode = 0;
  int stall_cnt = 0;
  int hold_cnt = 0;
  always @(negedge clk) begin
    if (hold_cnt > 0) begin
      hold_cnt--;
      result_stall <= 1'b1;
    end else if (!hold_long && n_sent > 150) begin
      hold_long = 1'b1;
      hold_cnt = 200;
      result_stall <= 1'b1;
    end else begin
      if (stall_cnt == 0) begin
        stall_mode = $urandom_range(0, 2);
        stall_cnt = $urandom_range(5, 60);
      end
      stall_cnt--;
      case (stall_mode)
        0: result_stall <= 1'b0;
        1: result_stall <= ($urandom_range(0, 3) == 0);
        default: result_stall <= ($urandom_range(0, 1) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    out_item_t exp_r;
    if (!rst && result_valid && !result_stall) begin
      if (events_q.size() == 0) begin
        $error("unexpected transfer: event_res %0d", result.event_res);
        errors++;
      end else begin
        exp_r = events_q.pop_front();
        if (result.event_res !== exp_r.event_res) begin
          $error("event_res exp %0d got %0d", exp_r.event_res, result.event_res); errors++;
        end
        if (result.char_code !== exp_r.char_code) begin
          $error("char_code exp %0h got %0h", exp_r.char_code, result.char_code); errors++;
        end
        if (result.nonblank !== exp_r.nonblank) begin
          $error("nonblank exp %0b got %0b", exp_r.nonblank, result.nonblank); errors++;
        end
        if (result.error_line !== exp_r.error_line) begin
          $error("error_line exp %0d got %0d", exp_r.error_line, result.error_line); errors++;
        end
        if (result.error_column !== exp_r.error_column) begin
          $error("error_column exp %0d got %0d", exp_r.error_column, result.error_column);
          errors++;
        end
        if (result.last !== exp_r.last) begin
          $error("last exp %0b got %0b", exp_r.last, result.last); errors++;
        end
      end
    end
  end

  int cycles = 0;
  initial parser_clear();
  always @(posedge clk) begin
    cycles++;
    if (stim_done) begin
      if (errors == 0 && events_q.size() == 0) $display("end of test: clean");
      else $display("end of test: mismatches");
      $finish;
    end else if (cycles > 400000) begin
      $display("end of test: mismatches");
      $finish;
    end
  end
endmodule
